// File: hdl/arfla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package arfla_pkg;
  localparam int DEF_MAX_RANGES = 24;
  localparam int DEF_PAGE_SHIFT = 12;
  localparam int ADDR_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_INVALID    = 2'd2;
  localparam logic [1:0] ST_FRAGMENTED = 2'd3;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      unused_pad;
  } arfla_dummy_t;
endpackage
`default_nettype wire

// File: hdl/arfla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module arfla_ram #(
  parameter int DEPTH = 24,
  parameter int DW    = 133
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: hdl/address_range_free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | func, start_address, end_address
// out     | output    | out_valid/out_ready | granted_address, span_length, status
// cfg     | input     | cfg_we              | cfg_index, cfg_wdata
// One item at a time: setup in S_LEN and S_SUM, then per free range visited one
// memory read (S_RD) and one check (S_CHK); an allocation writes back in S_CHK, a
// free in S_END and, if needed, S_WR2. The walk over the linked list in the range memory dominates.
// Reset (synchronous, rst_n low) and every config write to window base or size leave one free range.
// A waiting result holds the block in its final state until out_ready.
module address_range_free_list_allocator
  import arfla_pkg::*;
#(
  parameter int MAX_RANGES = DEF_MAX_RANGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_func,
  input  wire logic [ADDR_W-1:0]    in_start_address,
  input  wire logic [ADDR_W-1:0]    in_end_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [ADDR_W-1:0]    out_granted_address,
  output logic      [ADDR_W-1:0]    out_span_length,
  output logic      [1:0]           out_status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata
);
  localparam int LW = $clog2(MAX_RANGES + 1);
  localparam int IW = $clog2(MAX_RANGES);
  localparam int DW = 2 * ADDR_W + LW;
  localparam logic [LW-1:0] NIL = LW'(MAX_RANGES);
  localparam logic [ADDR_W-1:0] PMASK = (64'd1 << PAGE_SHIFT) - 64'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_LEN, S_SUM, S_RD, S_CHK, S_END, S_WR2, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic func_r, func_nxt, lenok_r, lenok_nxt, wrap_r, wrap_nxt, curv_r, curv_nxt;
  logic [ADDR_W-1:0] ab_r, ab_nxt, diff_r, diff_nxt, len_r, len_nxt, ae_r, ae_nxt;
  logic [ADDR_W-1:0] pd_s_r, pd_s_nxt, pd_e_r, pd_e_nxt, cd_s_r, cd_s_nxt;
  logic [ADDR_W-1:0] cd_e_r, cd_e_nxt;
  logic [LW-1:0] pd_l_r, pd_l_nxt, cd_l_r, cd_l_nxt, cur_r, cur_nxt, prev_r, prev_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt, slot_r, slot_nxt, head_r, head_nxt, free_slot;
  logic [MAX_RANGES-1:0] valid_r, valid_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt, size_r, size_nxt, wend_r, wend_nxt;
  logic [ADDR_W-1:0] res_g_r, res_g_nxt, res_l_r, res_l_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_g_r, out_g_nxt, out_l_r, out_l_nxt;
  logic [1:0] out_st_r, out_st_nxt;

  logic          m_re, m_we;
  logic [IW-1:0] m_raddr, m_waddr;
  logic [DW-1:0] m_rdata, m_wdata;
  logic [ADDR_W-1:0] d_s, d_e, have, lo, hi, cfg_b, cfg_s;
  logic [LW-1:0] d_l;
  logic [ADDR_W:0] sum65;

  arfla_ram #(.DEPTH(MAX_RANGES), .DW(DW)) u_ram (
    .clk(clk), .re(m_re), .raddr(m_raddr), .rdata(m_rdata),
    .we(m_we), .waddr(m_waddr), .wdata(m_wdata)
  );

  assign d_s  = m_rdata[DW-1 -: ADDR_W];
  assign d_e  = m_rdata[LW +: ADDR_W];
  assign d_l  = m_rdata[LW-1:0];
  assign have = d_e - d_s;
  assign lo   = (prev_r != NIL) ? pd_e_r : base_r;
  assign hi   = curv_r ? cd_s_r : wend_r;

  always_comb begin
    free_slot = NIL;
    for (int i = MAX_RANGES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = LW'(i);
      end
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_granted_address = out_g_r;
  assign out_span_length     = out_l_r;
  assign out_status          = out_st_r;

  always_comb begin
    state_nxt = state_r; func_nxt = func_r; lenok_nxt = lenok_r; wrap_nxt = wrap_r;
    curv_nxt = curv_r; ab_nxt = ab_r; diff_nxt = diff_r; len_nxt = len_r; ae_nxt = ae_r;
    pd_s_nxt = pd_s_r; pd_e_nxt = pd_e_r; pd_l_nxt = pd_l_r;
    cd_s_nxt = cd_s_r; cd_e_nxt = cd_e_r; cd_l_nxt = cd_l_r;
    cur_nxt = cur_r; prev_nxt = prev_r; cnt_nxt = cnt_r; slot_nxt = slot_r;
    head_nxt = head_r; valid_nxt = valid_r;
    base_nxt = base_r; size_nxt = size_r; wend_nxt = wend_r;
    res_g_nxt = res_g_r; res_l_nxt = res_l_r; res_st_nxt = res_st_r;
    out_valid_nxt = out_valid_r; out_g_nxt = out_g_r; out_l_nxt = out_l_r;
    out_st_nxt = out_st_r;
    m_re = 1'b0; m_raddr = cur_r[IW-1:0];
    m_we = 1'b0; m_waddr = cur_r[IW-1:0]; m_wdata = '0;
    sum65 = '0; cfg_b = base_r; cfg_s = size_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          ab_nxt    = in_start_address & ~PMASK;
          diff_nxt  = in_end_address - (in_start_address & ~PMASK);
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        lenok_nxt = (diff_r <= ~PMASK);
        len_nxt   = (diff_r <= ~PMASK) ? ((diff_r + PMASK) & ~PMASK) : '0;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum65     = {1'b0, ab_r} + {1'b0, len_r};
        ae_nxt    = sum65[ADDR_W-1:0];
        wrap_nxt  = sum65[ADDR_W];
        cur_nxt   = (head_r < NIL) ? head_r : NIL;
        prev_nxt  = NIL;
        cnt_nxt   = '0;
        curv_nxt  = 1'b0;
        res_l_nxt = len_r;
        res_g_nxt = (func_r == FUNC_FREE) ? ab_r : '0;
        res_st_nxt = ST_OK;
        state_nxt = S_RD;
        if (func_r == FUNC_ALLOC && !lenok_r) begin
          res_st_nxt = ST_EXHAUSTED;
          state_nxt  = S_DONE;
        end else if (func_r == FUNC_FREE && (!lenok_r || sum65[ADDR_W])) begin
          res_st_nxt = ST_INVALID;
          state_nxt  = S_DONE;
        end else if (func_r == FUNC_FREE && len_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        if (cur_r >= NIL || cnt_r == NIL) begin
          curv_nxt  = 1'b0;
          state_nxt = S_END;
        end else begin
          m_re      = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = S_RD;
        if (func_r == FUNC_ALLOC && have >= len_r) begin
          res_g_nxt = d_s;
          state_nxt = S_DONE;
          if (have == len_r) begin
            valid_nxt[cur_r[IW-1:0]] = 1'b0;
            if (prev_r == NIL) begin
              head_nxt = (d_l < NIL) ? d_l : NIL;
            end else begin
              m_we    = 1'b1;
              m_waddr = prev_r[IW-1:0];
              m_wdata = {pd_s_r, pd_e_r, (d_l < NIL) ? d_l : NIL};
            end
          end else begin
            m_we    = 1'b1;
            m_wdata = {d_s + len_r, d_e, d_l};
          end
        end else if (func_r == FUNC_FREE && ab_r < d_s) begin
          curv_nxt  = 1'b1;
          cd_s_nxt  = d_s;
          cd_e_nxt  = d_e;
          cd_l_nxt  = d_l;
          state_nxt = S_END;
        end else begin
          prev_nxt = cur_r;
          pd_s_nxt = d_s;
          pd_e_nxt = d_e;
          pd_l_nxt = d_l;
          cur_nxt  = (d_l < NIL) ? d_l : NIL;
          cnt_nxt  = cnt_r + LW'(1);
        end
      end
      S_END: begin
        state_nxt = S_DONE;
        if (func_r == FUNC_ALLOC) begin
          res_st_nxt = ST_EXHAUSTED;
        end else if (!(lo <= ab_r && ae_r <= hi)) begin
          res_st_nxt = ST_INVALID;
        end else if (curv_r && ae_r == cd_s_r) begin
          m_we = 1'b1;
          if (prev_r != NIL && pd_e_r == ab_r) begin
            m_waddr = prev_r[IW-1:0];
            m_wdata = {pd_s_r, cd_e_r, cd_l_r};
            valid_nxt[cur_r[IW-1:0]] = 1'b0;
          end else begin
            m_wdata = {ab_r, cd_e_r, cd_l_r};
          end
        end else if (prev_r != NIL && pd_e_r == ab_r) begin
          m_we    = 1'b1;
          m_waddr = prev_r[IW-1:0];
          m_wdata = {pd_s_r, ae_r, pd_l_r};
        end else if (free_slot == NIL) begin
          res_st_nxt = ST_FRAGMENTED;
        end else begin
          m_we     = 1'b1;
          m_waddr  = free_slot[IW-1:0];
          m_wdata  = {ab_r, ae_r, curv_r ? cur_r : NIL};
          valid_nxt[free_slot[IW-1:0]] = 1'b1;
          slot_nxt = free_slot;
          if (prev_r == NIL) begin
            head_nxt = free_slot;
          end else begin
            state_nxt = S_WR2;
          end
        end
      end
      S_WR2: begin
        m_we      = 1'b1;
        m_waddr   = prev_r[IW-1:0];
        m_wdata   = {pd_s_r, pd_e_r, slot_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_g_nxt     = res_g_r;
          out_l_nxt     = res_l_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we && (cfg_index == CFG_WINDOW_BASE || cfg_index == CFG_WINDOW_SIZE)) begin
      if (cfg_index == CFG_WINDOW_BASE) begin
        cfg_b = cfg_wdata;
      end else begin
        cfg_s = cfg_wdata;
      end
      base_nxt  = cfg_b;
      size_nxt  = cfg_s;
      sum65     = {1'b0, cfg_b} + {1'b0, cfg_s};
      wend_nxt  = sum65[ADDR_W] ? '1 : sum65[ADDR_W-1:0];
      head_nxt  = '0;
      valid_nxt = MAX_RANGES'(1);
      m_we      = 1'b1;
      m_waddr   = '0;
      m_wdata   = {cfg_b, sum65[ADDR_W-1:0], NIL};
    end

    // load entry 0 with the empty reset window
    if (!rst_n) begin
      m_we    = 1'b1;
      m_waddr = '0;
      m_wdata = {{(2 * ADDR_W){1'b0}}, NIL};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      valid_r     <= MAX_RANGES'(1);
      base_r      <= '0;
      size_r      <= '0;
      wend_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      valid_r     <= valid_nxt;
      base_r      <= base_nxt;
      size_r      <= size_nxt;
      wend_r      <= wend_nxt;
    end
    func_r <= func_nxt; lenok_r <= lenok_nxt; wrap_r <= wrap_nxt; curv_r <= curv_nxt;
    ab_r <= ab_nxt; diff_r <= diff_nxt; len_r <= len_nxt; ae_r <= ae_nxt;
    pd_s_r <= pd_s_nxt; pd_e_r <= pd_e_nxt; pd_l_r <= pd_l_nxt;
    cd_s_r <= cd_s_nxt; cd_e_r <= cd_e_nxt; cd_l_r <= cd_l_nxt;
    cur_r <= cur_nxt; prev_r <= prev_nxt; cnt_r <= cnt_nxt; slot_r <= slot_nxt;
    res_g_r <= res_g_nxt; res_l_r <= res_l_nxt; res_st_r <= res_st_nxt;
    out_g_r <= out_g_nxt; out_l_r <= out_l_nxt; out_st_r <= out_st_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("block idle right after an input transfer");
  a_cfg_init: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CFG_WINDOW_BASE || cfg_index == CFG_WINDOW_SIZE))
    |=> (head_r == '0 && valid_r == MAX_RANGES'(1)))
    else $error("free list not reinitialized by a config write");
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && head_r < NIL) |-> valid_r[head_r[IW-1:0]])
    else $error("list head points to a free table entry");
  a_wrap_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && wrap_r && func_r == FUNC_FREE) |-> 1'b0)
    else $error("wrapping free span entered the list walk");
endmodule
`default_nettype wire
